// ----- rtl/tcr_pkg.sv -----
// Shared types and encoding constants of the Thumb code relocator.
package tcr_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int PRE_SLOTS   = 12;

	localparam logic [15:0] HW_LDRW_PC_0 = 16'hF8DF;
	localparam logic [15:0] HW_LDRW_PC_1 = 16'hF000;
	localparam logic [15:0] HW_B_SKIP6   = 16'hE003;
	localparam logic [15:0] HW_LDR_LIT   = 16'h4800;
	localparam logic [15:0] HW_B_SKIP2   = 16'hE001;
	localparam logic [15:0] HW_B_SKIP4   = 16'hE002;
	localparam logic [15:0] HW_NOP       = 16'hBF00;
	localparam logic [15:0] HW_ADDW_LR_0 = 16'hF20F;
	localparam logic [15:0] HW_ADDW_LR_1 = 16'h0E09;
	localparam logic [15:0] HW_PUSH      = 16'hB400;
	localparam logic [15:0] HW_POP       = 16'hBC00;
	localparam logic [15:0] HW_BCOND     = 16'hD000;
	localparam logic [15:0] HW_BX_PC     = 16'h4778;
	localparam logic [15:0] HW_TB_HI     = 16'hE8DF;

	// One rewritten instruction: fixed halfwords, an optional literal word,
	// and the return jump when the item closes the run.
	typedef struct packed {
		logic [PRE_SLOTS-1:0][15:0] pre;
		logic [3:0]                 npre;
		logic                       word_en;
		logic                       fill;
		logic [31:0]                word;
		logic                       fin;
		logic [31:0]                ret;
	} tcr_job_t;

endpackage

// ----- rtl/thumb_code_relocator.sv -----
// Top level of the Thumb code relocator.
// Feed original Thumb code one halfword per item on the push/full side, in
// address order, with final_halfword set on the last one of the run. Each
// item that completes an instruction yields 2 to 18 result halfwords, read
// from the empty/pop side; run_end marks the last result of that item. The
// first half of a 32-bit instruction yields nothing on its own.
// Results flagged fill_from_memory come in pairs: the host replaces them with
// the word it loads from the address they hold.
// The emitter sends one halfword per cycle while the result ports are free or
// popped, so an item's results go out one after another (2 for a copy, 4 for most
// rewrites, up to 18 for a table branch closing a run). The front end takes
// one item per cycle while its two-entry job queue has room.
// The first result of an item passes through stage 1, the job queue and the
// output register before it reaches the result ports.
// target_address is written on cfg_valid (cfg_ready is always high) and is
// sampled when each halfword is accepted.
// Reset clears the run state, the queue and the output valid flag; a stall on
// pop holds the current result and backs up the queue, then raises full.
module thumb_code_relocator #(
	parameter int MAX_PATCH_HALFWORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] target_address,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_halfword,
	input  logic        final_halfword,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] out_halfword,
	output logic        fill_from_memory,
	output logic        run_end
);
	import tcr_pkg::*;

	tcr_job_t front_job;
	tcr_job_t head_job;
	logic     front_valid;
	logic     front_ready;
	logic     head_valid;
	logic     head_pop;

	assign cfg_ready = 1'b1;

	tcr_front #(
		.MAX_PATCH_HALFWORDS(MAX_PATCH_HALFWORDS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.target_address(target_address),
		.push          (push),
		.full          (full),
		.code_halfword (code_halfword),
		.final_halfword(final_halfword),
		.job_valid     (front_valid),
		.job_ready     (front_ready),
		.job           (front_job)
	);

	tcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_job    (front_job),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.head_job  (head_job)
	);

	tcr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (head_valid),
		.job_pop         (head_pop),
		.job             (head_job),
		.empty           (empty),
		.pop             (pop),
		.out_halfword    (out_halfword),
		.fill_from_memory(fill_from_memory),
		.run_end         (run_end)
	);

endmodule

// ----- rtl/tcr_front.sv -----
// Front end: takes halfwords, pairs 32-bit halves, classifies and builds jobs.
module tcr_front #(
	parameter int MAX_PATCH_HALFWORDS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [31:0]      target_address,
	input  logic             push,
	output logic             full,
	input  logic [15:0]      code_halfword,
	input  logic             final_halfword,
	output logic             job_valid,
	input  logic             job_ready,
	output tcr_pkg::tcr_job_t job
);
	import tcr_pkg::*;

	localparam int CW = $clog2(MAX_PATCH_HALFWORDS + 1);
	localparam logic [CW-1:0] MAXC  = CW'(MAX_PATCH_HALFWORDS);
	localparam logic [CW-1:0] LASTC = CW'(MAX_PATCH_HALFWORDS - 1);

	logic [31:0]   target_q;
	logic [15:0]   held_q;
	logic          pending_q;
	logic [CW-1:0] consumed_q;

	logic        valid_s1;
	logic        is32_s1;
	logic [15:0] hi_s1;
	logic [15:0] lo_s1;
	logic [31:0] pc_s1;
	logic [31:0] ret_s1;
	logic        fin_s1;

	logic          accept;
	logic [CW-1:0] pos;
	logic [CW-1:0] newc;
	logic [CW-1:0] start;
	logic          fin;
	logic          hold;
	logic [31:0]   base;
	logic [31:0]   pc_in;
	logic [31:0]   ret_in;

	assign full   = valid_s1 & ~job_ready;
	assign accept = push & ~full;
	assign pos    = (consumed_q >= MAXC) ? LASTC : consumed_q;
	assign newc   = pos + CW'(1);
	assign fin    = final_halfword | (newc >= MAXC);
	assign hold   = ~pending_q & (code_halfword[15:11] >= 5'h1D) & ~fin;
	assign start  = pending_q ? ((pos != '0) ? pos - CW'(1) : '0) : pos;
	assign base   = {target_q[31:1], 1'b0};
	assign pc_in  = base + 32'd4 + 32'({start, 1'b0});
	assign ret_in = base + 32'({newc, 1'b0}) + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			held_q     <= '0;
			pending_q  <= 1'b0;
			consumed_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				target_q <= target_address;
			end
			if (accept) begin
				if (pending_q) begin
					pending_q <= 1'b0;
				end else if (hold) begin
					held_q    <= code_halfword;
					pending_q <= 1'b1;
				end
				if (fin) begin
					consumed_q <= '0;
					pending_q  <= 1'b0;
				end else begin
					consumed_q <= newc;
				end
			end
			if (accept && !hold) begin
				valid_s1 <= 1'b1;
			end else if (job_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !hold) begin
			is32_s1 <= pending_q;
			hi_s1   <= held_q;
			lo_s1   <= code_halfword;
			pc_s1   <= pc_in;
			ret_s1  <= ret_in;
			fin_s1  <= fin;
		end
	end

	// classification of the instruction held in stage 1
	logic [31:0] apc;
	logic [31:0] sx9;
	logic [31:0] sx12;
	logic [3:0]  cond;
	logic        s, j1, j2, i1, i2;
	logic [31:0] xc;
	logic [31:0] xu;
	logic [31:0] imm_adr;
	logic [31:0] imm_ldr;
	logic        is_br;
	logic [2:0]  rdn_r;
	logic [3:0]  rdn;
	logic [3:0]  rm;
	logic [2:0]  tr;
	logic [2:0]  rx;

	assign apc     = {pc_s1[31:2], 2'b00};
	assign sx9     = {{23{lo_s1[7]}}, lo_s1[7:0], 1'b0};
	assign sx12    = {{20{lo_s1[10]}}, lo_s1[10:0], 1'b0};
	assign cond    = hi_s1[9:6];
	assign s       = hi_s1[10];
	assign j1      = lo_s1[13];
	assign j2      = lo_s1[11];
	assign i1      = ~(j1 ^ s);
	assign i2      = ~(j2 ^ s);
	assign xc      = {{11{s}}, s, j2, j1, hi_s1[5:0], lo_s1[10:0], 1'b0};
	assign xu      = {{7{s}}, s, i1, i2, hi_s1[9:0], lo_s1[10:0], 1'b0};
	assign imm_adr = {20'd0, hi_s1[10], lo_s1[14:12], lo_s1[7:0]};
	assign imm_ldr = {20'd0, lo_s1[11:0]};
	assign is_br   = (hi_s1[15:11] == 5'b11110) && (lo_s1[15] == 1'b1) &&
		((lo_s1[14] == 1'b1) || (lo_s1[12] == 1'b1) || (cond < 4'hE));
	assign rdn     = {lo_s1[7], lo_s1[2:0]};
	assign rdn_r   = (rdn == 4'd7) ? 3'd6 : 3'd7;
	assign rm      = lo_s1[3:0];
	assign tr      = (rm == 4'd7) ? 3'd6 : 3'd7;
	assign rx      = ((rm == 4'd7) || (rm == 4'd6)) ? 3'd5 : 3'd6;

	always_comb begin
		job         = '0;
		job.fin     = fin_s1;
		job.ret     = ret_s1;
		job.word_en = 1'b1;
		job.pre[0]  = HW_LDRW_PC_0;
		job.pre[1]  = HW_LDRW_PC_1;
		job.npre    = 4'd2;
		if (!is32_s1) begin
			priority if (lo_s1[15:12] == 4'hD && lo_s1[11:8] < 4'hE) begin
				job.pre[0] = lo_s1 & 16'hFF00;
				job.pre[1] = HW_B_SKIP6;
				job.pre[2] = HW_LDRW_PC_0;
				job.pre[3] = HW_LDRW_PC_1;
				job.npre   = 4'd4;
				job.word   = pc_s1 + sx9 + 32'd1;
			end else if (lo_s1[15:11] == 5'b11100) begin
				job.word = pc_s1 + sx12 + 32'd1;
			end else if ((lo_s1 & 16'hFFF8) == HW_BX_PC) begin
				job.word = pc_s1;
			end else if ((lo_s1 & 16'hFF78) == 16'h4478) begin
				job.pre[0] = HW_PUSH | (16'h0001 << rdn_r);
				job.pre[1] = 16'h4802 | {5'd0, rdn_r, 8'd0};
				job.pre[2] = (lo_s1 & 16'hFF87) | {10'd0, rdn_r, 3'd0};
				job.pre[3] = HW_POP | (16'h0001 << rdn_r);
				job.pre[4] = HW_B_SKIP4;
				job.pre[5] = HW_NOP;
				job.npre   = 4'd6;
				job.word   = pc_s1;
			end else if ((lo_s1 & 16'hFF78) == 16'h4678) begin
				job.pre[0] = HW_LDR_LIT | {5'd0, lo_s1[2:0], 8'd0};
				job.pre[1] = HW_B_SKIP2;
				job.word   = pc_s1;
			end else if (lo_s1[15:11] == 5'b10100 || lo_s1[15:11] == 5'b01001) begin
				job.pre[0] = HW_LDR_LIT | {5'd0, lo_s1[10:8], 8'd0};
				job.pre[1] = HW_B_SKIP2;
				job.word   = apc + {22'd0, lo_s1[7:0], 2'b00};
				job.fill   = (lo_s1[15:11] == 5'b01001);
			end else begin
				job.pre[0]  = lo_s1;
				job.pre[1]  = HW_NOP;
				job.word_en = 1'b0;
			end
		end else begin
			priority if (is_br) begin
				job.npre   = 4'd4;
				job.pre[2] = HW_LDRW_PC_0;
				job.pre[3] = HW_LDRW_PC_1;
				if (lo_s1[14]) begin
					job.pre[0] = HW_ADDW_LR_0;
					job.pre[1] = HW_ADDW_LR_1;
				end else if (!lo_s1[12]) begin
					job.pre[0] = HW_BCOND | {4'd0, cond, 8'd0};
					job.pre[1] = HW_B_SKIP6;
				end else begin
					job.pre[0] = HW_LDRW_PC_0;
					job.pre[1] = HW_LDRW_PC_1;
					job.npre   = 4'd2;
				end
				if (lo_s1[14] && !lo_s1[12]) begin
					job.word = apc + {xu[31:2], 2'b00};
				end else if (lo_s1[12]) begin
					job.word = pc_s1 + xu + 32'd1;
				end else begin
					job.word = pc_s1 + xc + 32'd1;
				end
			end else if (((hi_s1 & 16'hFBFF) == 16'hF2AF || (hi_s1 & 16'hFBFF) == 16'hF20F)
				&& !lo_s1[15]) begin
				job.pre[0] = HW_LDR_LIT | {4'd0, lo_s1[11:8], 8'd0};
				job.pre[1] = HW_B_SKIP2;
				job.word   = (hi_s1[7]) ? apc - imm_adr : apc + imm_adr;
			end else if ((hi_s1 & 16'hFF7F) == 16'hF85F) begin
				job.pre[0] = HW_LDR_LIT | {4'd0, lo_s1[15:12], 8'd0};
				job.pre[1] = HW_B_SKIP2;
				job.word   = (hi_s1[7]) ? apc + imm_ldr : apc - imm_ldr;
				job.fill   = 1'b1;
			end else if (hi_s1 == HW_TB_HI && (lo_s1 & 16'h00E0) == 16'h0000) begin
				job.pre[0] = HW_PUSH | (16'h0001 << rx);
				job.pre[1] = 16'h4805 | {5'd0, tr, 8'd0};
				job.pre[2] = 16'h4600 | {9'd0, rm, rx};
				job.pre[3] = 16'hEB00 | {13'd0, tr};
				if (lo_s1[4]) begin
					job.pre[4] = 16'h0040 | {5'd0, rx, 5'd0, rx};
					job.pre[5] = 16'h8800 | {10'd0, rx, rx};
				end else begin
					job.pre[4] = {5'd0, rx, 5'd0, rx};
					job.pre[5] = 16'h7800 | {10'd0, rx, rx};
				end
				job.pre[6]  = 16'hEB00 | {13'd0, tr};
				job.pre[7]  = 16'h0040 | {5'd0, tr, 5'd0, rx};
				job.pre[8]  = 16'h3001 | {5'd0, tr, 8'd0};
				job.pre[9]  = HW_POP | (16'h0001 << rx);
				job.pre[10] = 16'h4700 | {10'd0, tr, 3'd0};
				job.pre[11] = HW_NOP;
				job.npre    = 4'd12;
				job.word    = pc_s1;
			end else begin
				job.pre[0]  = hi_s1;
				job.pre[1]  = lo_s1;
				job.word_en = 1'b0;
			end
		end
	end

	assign job_valid = valid_s1;

endmodule

// ----- rtl/tcr_queue.sv -----
// Short job queue between the front end and the emitter.
module tcr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcr_pkg::tcr_job_t in_job,
	output logic              head_valid,
	input  logic              head_pop,
	output tcr_pkg::tcr_job_t head_job
);
	import tcr_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	tcr_job_t      mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr;
	logic          rd;

	assign in_ready   = (cnt_q != CW'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rp_q];
	assign wr         = in_valid & in_ready;
	assign rd         = head_pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= in_job;
		end
	end

endmodule

// ----- rtl/tcr_back.sv -----
// Emitter: walks the head job and sends one halfword per cycle while the output is free or popped.
module tcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_pop,
	input  tcr_pkg::tcr_job_t job,
	output logic              empty,
	input  logic              pop,
	output logic [15:0]       out_halfword,
	output logic              fill_from_memory,
	output logic              run_end
);
	import tcr_pkg::*;

	logic [4:0]  idx_q;
	logic        out_valid_q;
	logic [4:0]  total;
	logic [4:0]  wend;
	logic [4:0]  rel;
	logic        last;
	logic        advance;
	logic [15:0] hw;
	logic        fl;

	assign wend    = {1'b0, job.npre} + (job.word_en ? 5'd2 : 5'd0);
	assign total   = wend + (job.fin ? 5'd4 : 5'd0);
	assign last    = (idx_q == total - 5'd1);
	assign rel     = idx_q - wend;
	assign advance = job_valid & (~out_valid_q | pop);
	assign job_pop = advance & last;
	assign empty   = ~out_valid_q;

	always_comb begin
		hw = HW_NOP;
		fl = 1'b0;
		priority if (idx_q < {1'b0, job.npre}) begin
			hw = job.pre[idx_q[3:0]];
		end else if (idx_q < wend) begin
			hw = (idx_q == {1'b0, job.npre}) ? job.word[15:0] : job.word[31:16];
			fl = job.fill;
		end else begin
			unique case (rel[1:0])
				2'd0: hw = HW_LDRW_PC_0;
				2'd1: hw = HW_LDRW_PC_1;
				2'd2: hw = job.ret[15:0];
				2'd3: hw = job.ret[31:16];
				default: hw = HW_NOP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 5'd0 : idx_q + 5'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_halfword     <= hw;
			fill_from_memory <= fl;
			run_end          <= last;
		end
	end

endmodule

// ----- test/thumb_code_relocator_test.sv -----
// Testbench for the Thumb code relocator: predicted result halfwords checked in order.
`timescale 1ns / 1ps

class relocation_scoreboard;
	bit [31:0] base_address;
	bit [15:0] held_half;
	bit        half_pending;
	int        consumed;
	bit [17:0] pending_halfwords[$];
	int        errors;
	int        checked;

	function void add_hw(bit [15:0] hw, bit fill);
		pending_halfwords.push_back({hw, fill, 1'b0});
	endfunction

	function void add_word(bit [31:0] w, bit fill);
		add_hw(w[15:0], fill);
		add_hw(w[31:16], fill);
	endfunction

	function void add_load(bit [3:0] r, bit [31:0] w, bit fill);
		add_hw(tcr_pkg::HW_LDR_LIT | {4'd0, r, 8'd0}, 1'b0);
		add_hw(tcr_pkg::HW_B_SKIP2, 1'b0);
		add_word(w, fill);
	endfunction

	function void add_jump(bit [31:0] dest);
		add_hw(tcr_pkg::HW_LDRW_PC_0, 1'b0);
		add_hw(tcr_pkg::HW_LDRW_PC_1, 1'b0);
		add_word(dest, 1'b0);
	endfunction

	function void relocate_short(bit [31:0] pc, bit [15:0] ins);
		bit [31:0] x, apc;
		bit [3:0]  rdn;
		bit [2:0]  r;
		apc = pc & 32'hFFFF_FFFC;
		if (ins[15:12] == 4'hD && ins[11:8] < 4'hE) begin
			x = {{23{ins[7]}}, ins[7:0], 1'b0};
			add_hw(ins & 16'hFF00, 1'b0);
			add_hw(tcr_pkg::HW_B_SKIP6, 1'b0);
			add_jump(pc + x + 1);
		end else if (ins[15:11] == 5'b11100) begin
			x = {{20{ins[10]}}, ins[10:0], 1'b0};
			add_jump(pc + x + 1);
		end else if ((ins & 16'hFFF8) == tcr_pkg::HW_BX_PC) begin
			add_jump(pc);
		end else if ((ins & 16'hFF78) == 16'h4478) begin
			rdn = {ins[7], ins[2:0]};
			r = (rdn == 4'd7) ? 3'd6 : 3'd7;
			add_hw(tcr_pkg::HW_PUSH | (16'd1 << r), 1'b0);
			add_hw(16'h4802 | {5'd0, r, 8'd0}, 1'b0);
			add_hw((ins & 16'hFF87) | {10'd0, r, 3'd0}, 1'b0);
			add_hw(tcr_pkg::HW_POP | (16'd1 << r), 1'b0);
			add_hw(tcr_pkg::HW_B_SKIP4, 1'b0);
			add_hw(tcr_pkg::HW_NOP, 1'b0);
			add_word(pc, 1'b0);
		end else if ((ins & 16'hFF78) == 16'h4678) begin
			add_load({1'b0, ins[2:0]}, pc, 1'b0);
		end else if (ins[15:11] == 5'b10100) begin
			add_load({1'b0, ins[10:8]}, apc + {22'd0, ins[7:0], 2'd0}, 1'b0);
		end else if (ins[15:11] == 5'b01001) begin
			add_load({1'b0, ins[10:8]}, apc + {22'd0, ins[7:0], 2'd0}, 1'b1);
		end else begin
			add_hw(ins, 1'b0);
			add_hw(tcr_pkg::HW_NOP, 1'b0);
		end
	endfunction

	function void relocate_wide(bit [31:0] pc, bit [15:0] hi, bit [15:0] lo);
		bit [31:0] ins, apc, br, x, dest, imm;
		bit [3:0]  cond, rm, r, rx;
		bit        j1, j2, s, i1, i2;
		ins = {hi, lo};
		apc = pc & 32'hFFFF_FFFC;
		br = ins & 32'hF800_D000;
		cond = hi[9:6];
		if (br == 32'hF000_C000 || br == 32'hF000_D000 || br == 32'hF000_9000 ||
				(br == 32'hF000_8000 && cond < 4'hE)) begin
			j1 = lo[13];
			j2 = lo[11];
			s = hi[10];
			i1 = ~(j1 ^ s);
			i2 = ~(j2 ^ s);
			if (br == 32'hF000_8000)
				x = {{12{s}}, j2, j1, hi[5:0], lo[10:0], 1'b0};
			else
				x = {{8{s}}, i1, i2, hi[9:0], lo[10:0], 1'b0};
			if (br == 32'hF000_C000 || br == 32'hF000_D000) begin
				add_hw(tcr_pkg::HW_ADDW_LR_0, 1'b0);
				add_hw(tcr_pkg::HW_ADDW_LR_1, 1'b0);
			end else if (br == 32'hF000_8000) begin
				add_hw(tcr_pkg::HW_BCOND | {4'd0, cond, 8'd0}, 1'b0);
				add_hw(tcr_pkg::HW_B_SKIP6, 1'b0);
			end
			dest = (br == 32'hF000_C000) ? apc + (x & 32'hFFFF_FFFC) : pc + x + 1;
			add_jump(dest);
		end else if ((ins & 32'hFBFF_8000) == 32'hF2AF_0000 ||
				(ins & 32'hFBFF_8000) == 32'hF20F_0000) begin
			imm = {20'd0, hi[10], lo[14:12], lo[7:0]};
			add_load(lo[11:8], hi[7] ? apc - imm : apc + imm, 1'b0);
		end else if ((ins & 32'hFF7F_0000) == 32'hF85F_0000) begin
			imm = {20'd0, lo[11:0]};
			add_load(lo[15:12], hi[7] ? apc + imm : apc - imm, 1'b1);
		end else if ((ins & 32'hFFFF_00E0) == 32'hE8DF_0000) begin
			rm = lo[3:0];
			r = (rm == 4'd7) ? 4'd6 : 4'd7;
			rx = 4'd7;
			while (rx == rm || rx == r)
				rx--;
			add_hw(tcr_pkg::HW_PUSH | (16'd1 << rx), 1'b0);
			add_hw(16'h4805 | {4'd0, r, 8'd0}, 1'b0);
			add_hw(16'h4600 | {9'd0, rm, 3'd0} | {12'd0, rx}, 1'b0);
			add_hw(16'hEB00 | {12'd0, r}, 1'b0);
			if (lo[4]) begin
				add_hw(16'h0040 | {4'd0, rx, 8'd0} | {12'd0, rx}, 1'b0);
				add_hw(16'h8800 | {9'd0, rx, 3'd0} | {12'd0, rx}, 1'b0);
			end else begin
				add_hw({4'd0, rx, 8'd0} | {12'd0, rx}, 1'b0);
				add_hw(16'h7800 | {9'd0, rx, 3'd0} | {12'd0, rx}, 1'b0);
			end
			add_hw(16'hEB00 | {12'd0, r}, 1'b0);
			add_hw(16'h0040 | {4'd0, r, 8'd0} | {12'd0, rx}, 1'b0);
			add_hw(16'h3001 | {4'd0, r, 8'd0}, 1'b0);
			add_hw(tcr_pkg::HW_POP | (16'd1 << rx), 1'b0);
			add_hw(16'h4700 | {9'd0, r, 3'd0}, 1'b0);
			add_hw(tcr_pkg::HW_NOP, 1'b0);
			add_word(pc, 1'b0);
		end else begin
			add_hw(hi, 1'b0);
			add_hw(lo, 1'b0);
		end
	endfunction

	function void note_halfword(bit [15:0] hw, bit fin);
		bit [31:0] base;
		int        slot, prior_count;
		base = base_address & 32'hFFFF_FFFE;
		slot = consumed;
		prior_count = pending_halfwords.size();
		if (slot >= 64)
			slot = 63;
		consumed = slot + 1;
		if (consumed >= 64)
			fin = 1'b1;
		if (half_pending) begin
			half_pending = 1'b0;
			relocate_wide(base + 4 + 2 * ((slot != 0) ? slot - 1 : 0), held_half, hw);
		end else if (hw[15:11] >= 5'h1D && !fin) begin
			held_half = hw;
			half_pending = 1'b1;
			return;
		end else begin
			relocate_short(base + 4 + 2 * slot, hw);
		end
		if (fin) begin
			add_jump(base + 2 * consumed + 1);
			consumed = 0;
			half_pending = 1'b0;
		end
		if (pending_halfwords.size() > prior_count)
			pending_halfwords[pending_halfwords.size() - 1][0] = 1'b1;
	endfunction

	function void check_result(bit [15:0] hw, bit fill, bit last);
		bit [17:0] e;
		checked++;
		if (pending_halfwords.size() == 0) begin
			$error("result %h with nothing expected", hw);
			errors++;
			return;
		end
		e = pending_halfwords.pop_front();
		if (e[17:2] != hw) begin
			$error("out_halfword: expected %h, actual %h", e[17:2], hw);
			errors++;
		end
		if (e[1] != fill) begin
			$error("fill_from_memory: expected %b, actual %b", e[1], fill);
			errors++;
		end
		if (e[0] != last) begin
			$error("run_end: expected %b, actual %b", e[0], last);
			errors++;
		end
	endfunction
endclass

module thumb_code_relocator_test;
	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] target_address;
	logic        push;
	logic        full;
	logic [15:0] code_halfword;
	logic        final_halfword;
	logic        empty;
	logic        pop;
	logic [15:0] out_halfword;
	logic        fill_from_memory;
	logic        run_end;

	relocation_scoreboard board;
	int   send_idle_pct;
	int   take_idle_pct;
	int   cycle_count;
	int   item_count;

	thumb_code_relocator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.target_address(target_address), .push(push), .full(full),
		.code_halfword(code_halfword), .final_halfword(final_halfword),
		.empty(empty), .pop(pop), .out_halfword(out_halfword),
		.fill_from_memory(fill_from_memory), .run_end(run_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver: stall at random, check each popped result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				board.check_result(out_halfword, fill_from_memory, run_end);
			pop <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Push stays high between back-to-back items; drop it only while idling.
	task automatic send_item(bit [15:0] hw, bit fin);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		push <= 1'b1;
		code_halfword <= hw;
		final_halfword <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_halfword(hw, fin);
		item_count++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (board.pending_halfwords.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_base(bit [31:0] value);
		drain();
		cfg_valid <= 1'b1;
		target_address <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.base_address = value;
	endtask

	// Mostly PC-relative instructions with random fields, some plain noise.
	function automatic bit [31:0] random_instruction();
		bit [15:0] a, b;
		a = 16'($urandom);
		b = 16'($urandom);
		case ($urandom_range(13))
			0: return {16'd0, 4'hD, a[11:0]};
			1: return {16'd0, 5'b11100, a[10:0]};
			2: return {16'd0, 13'h08EF, a[2:0]};
			3: return {16'd0, 8'h44, a[7], 4'hF, a[2:0]};
			4: return {16'd0, 8'h46, a[7], 4'hF, a[2:0]};
			5: return {16'd0, 5'b10100, a[10:0]};
			6: return {16'd0, 5'b01001, a[10:0]};
			7: return {5'b11110, a[10:0], b[15:14], 1'b0, b[12:0]} | 32'h0000_8000;
			8: return {5'b11110, a[10:0], 2'b11, b[13:0]};
			9: return {5'b11110, a[10], 6'b101010, 4'hF, b};
			10: return {8'hF8, a[7], 7'h5F, b};
			11: return {16'hE8DF, 8'hF0, 3'b000, b[4:0]};
			12: return {5'b11110, a[10:0], b[15:14], 1'b0, b[12:0]};
			default: return {a, b};
		endcase
	endfunction

	task automatic send_instruction(bit [31:0] ins, bit fin);
		if (ins[31:16] != 0 || ins[15:11] >= 5'h1D) begin
			send_item(ins[31:16], 1'b0);
			send_item(ins[15:0], fin);
		end else begin
			send_item(ins[15:0], fin);
		end
	endtask

	task automatic random_phase(int count);
		int n;
		n = 0;
		while (n < count) begin
			int len;
			len = $urandom_range(6, 1);
			for (int k = 0; k < len; k++) begin
				send_instruction(random_instruction(), k == len - 1);
				n++;
			end
			if ($urandom_range(19) == 0)
				send_item(16'($urandom), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		target_address = '0;
		push = 1'b0;
		code_halfword = '0;
		final_halfword = 1'b0;
		send_idle_pct = 0;
		take_idle_pct = 0;
		item_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every rewrite kind but the wide conditional branch, the not-branch conditions, lone first halves.
		write_base(32'h0000_0000);
		send_item(16'hD0FF, 1'b0);
		send_item(16'hDE12, 1'b0);
		send_item(16'hDF34, 1'b0);
		send_item(16'hE400, 1'b0);
		send_item(16'h4778, 1'b0);
		send_item(16'h44FF, 1'b0);
		send_item(16'h4478, 1'b0);
		send_item(16'h46FF, 1'b0);
		send_item(16'hA7FF, 1'b0);
		send_item(16'h4FFF, 1'b1);
		write_base(32'hFFFF_FFFE);
		send_instruction(32'hF7FF_FFFE, 1'b0);
		send_instruction(32'hF000_E801, 1'b0);
		send_instruction(32'hF3C0_8000, 1'b0);
		send_instruction(32'hF7FF_BFFF, 1'b0);
		send_instruction(32'hF6AF_7FFF, 1'b0);
		send_instruction(32'hF20F_0F00, 1'b0);
		send_instruction(32'hF8DF_FFFF, 1'b0);
		send_instruction(32'hE8DF_F017, 1'b0);
		send_instruction(32'hE8DF_F007, 1'b0);
		send_item(16'hFFFF, 1'b1);
		write_base(32'h8000_0001);
		for (int k = 0; k < 70; k++)
			send_item(16'h0000, 1'b0);
		send_item(16'hE800, 1'b1);

		send_idle_pct = 7;
		take_idle_pct = 68;
		random_phase(72);
		drain();
		write_base($urandom & 32'hFFFF_FFFE);
		send_idle_pct = 68;
		take_idle_pct = 7;
		random_phase(72);
		// Base change, possibly mid-run and to an odd base: new base is taken with the next halfword.
		write_base($urandom);
		send_idle_pct = 0;
		take_idle_pct = 0;
		random_phase(72);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d halfwords in, %0d results checked, three idle mixes",
			item_count, board.checked);
		if (board.errors == 0 && board.pending_halfwords.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
